// ===== rtl/pcp_pkg.sv =====
// shared types and constants for the camera point projector
// used by pcp_div and camera_point_projector; no dependencies
`default_nettype none

package pcp_pkg;

    localparam int DEN_W = 51;
    localparam int REM_W = 64;
    localparam int QUO_W = 16;
    localparam int CMP_W = DEN_W + QUO_W;
    localparam int LANES = 3;

    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_R = 2;

    localparam logic [2:0] REG_CAM_X = 3'd0;
    localparam logic [2:0] REG_CAM_Y = 3'd1;
    localparam logic [2:0] REG_CAM_Z = 3'd2;
    localparam logic [2:0] REG_ROT0  = 3'd3;
    localparam logic [2:0] REG_ROT1  = 3'd4;
    localparam logic [2:0] REG_ROT2  = 3'd5;

    localparam logic signed [10:0] PROJ_SCALE = 11'sd1000;
    localparam logic [6:0] FAC_STAR   = 7'd100;
    localparam logic [6:0] FAC_PLANET = 7'd50;

    typedef struct packed {
        logic        vis;
        logic        star;
        logic [31:0] depth;
        logic [31:0] color;
    } side_t;

    typedef struct packed {
        logic [DEN_W-1:0]            den;
        logic [LANES-1:0][REM_W-1:0] rem;
        logic [LANES-1:0][QUO_W-1:0] quo;
        logic [LANES-1:0]            neg;
        logic [LANES-1:0]            ovf;
        side_t                       side;
    } div_t;

    function automatic logic signed [15:0] rot_ent(input logic [47:0] row, input int col);
        logic [15:0] e;
        e = row[47 - 16*col -: 16];
        return $signed(e);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/camera_point_projector.sv =====
// camera point projector top level: camera transform, cull and projection
// depends on pcp_pkg and pcp_div
//
// usage
//   s_axis carries one body per transfer, m_axis one result per body, in order.
//   cfg writes camera position and rotation rows; cfg_ready is always high.
//   write cfg only while no body is in flight.
// pipeline
//   five front stages (difference, products, sums, numerators, magnitudes),
//   sixteen divider stages (one quotient bit each), one saturation stage.
//   throughput, set by the fully pipelined divider, is one body per cycle
//   while m_axis_tready is high.
// reset
//   rst_n clears all stage valid bits, camera position to zero and the
//   rotation to identity.
// stall
//   each stage holds while the stage after it is full and stalled; bubbles
//   close up, so s_axis_tready drops only once every stage holds a body.
`default_nettype none

module camera_point_projector #(
    parameter int SCREEN_W = 1024,
    parameter int SCREEN_H = 768
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [159:0] s_axis_tdata,   // pos_x, pos_y, pos_z, body_radius, color
    input  wire logic [0:0]   s_axis_tuser,   // is_star
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [111:0]      m_axis_tdata,   // screen_x, screen_y, draw_radius, depth, color_out, pad
    output logic [1:0]        m_axis_tuser,   // visible, star_out
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [47:0]  cfg_data
);
    import pcp_pkg::*;

    localparam logic signed [14:0] HALF_W = 15'(SCREEN_W / 2);
    localparam logic signed [14:0] HALF_H = 15'(SCREEN_H / 2);

    logic [31:0]       cam_reg [3];
    logic [47:0]       rot_reg [3];

    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    logic              adv1, adv2, adv3, adv4, adv5, advo;
    logic              div_in_ready, div_out_valid;
    div_t              div_out;

    logic signed [32:0] rel_reg [3];
    logic signed [48:0] prod_reg [3][3];
    logic signed [50:0] loc_reg [3];
    logic [31:0]        rad1_reg, rad2_reg, rad3_reg;
    side_t              sd1_reg, sd2_reg, sd3_reg, sd4_reg;

    logic signed [63:0] nx_reg, ny_reg;
    logic [52:0]        nr_reg;
    logic [50:0]        z_reg;
    div_t               d5_reg;

    logic signed [63:0] nx_next, ny_next;
    logic [52:0]        nr_next;
    logic signed [54:0] z10;
    logic signed [50:0] zr;
    logic signed [36:0] zt;
    logic [31:0]        depth_next;
    logic               vis_next;
    side_t              sd4_next;
    div_t               d5_next;
    logic [63:0]        mag [3];

    logic [15:0]        sx_next, sy_next;
    logic [14:0]        r_next;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg[0] <= '0;
            cam_reg[1] <= '0;
            cam_reg[2] <= '0;
            rot_reg[0] <= 48'h4000_0000_0000;
            rot_reg[1] <= 48'h0000_4000_0000;
            rot_reg[2] <= 48'h0000_0000_4000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CAM_X: cam_reg[0] <= cfg_data[31:0];
                REG_CAM_Y: cam_reg[1] <= cfg_data[31:0];
                REG_CAM_Z: cam_reg[2] <= cfg_data[31:0];
                REG_ROT0:  rot_reg[0] <= cfg_data;
                REG_ROT1:  rot_reg[1] <= cfg_data;
                REG_ROT2:  rot_reg[2] <= cfg_data;
                default:   ;
            endcase
        end
    end

    // stage advance chain
    assign advo = !vo_reg || m_axis_tready;
    assign adv5 = !v5_reg || div_in_ready;
    assign adv4 = !v4_reg || adv5;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign s_axis_tready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= s_axis_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
            if (advo) vo_reg <= div_out_valid;
        end
    end

    // stage 1: position minus camera
    always_ff @(posedge clk)
    begin
        if (adv1 && s_axis_tvalid)
        begin
            for (int i = 0; i < 3; i++)
                rel_reg[i] <= $signed({s_axis_tdata[32*i+31], s_axis_tdata[32*i +: 32]})
                            - $signed({cam_reg[i][31], cam_reg[i]});
            rad1_reg <= s_axis_tdata[127:96];
            sd1_reg  <= '{vis: 1'b0, star: s_axis_tuser[0], depth: '0,
                          color: s_axis_tdata[159:128]};
        end
    end

    // stage 2: rotation products
    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= rot_ent(rot_reg[r], c) * rel_reg[r];
            rad2_reg <= rad1_reg;
            sd2_reg  <= sd1_reg;
        end
    end

    // stage 3: column sums, transpose of the rotation
    always_ff @(posedge clk)
    begin
        if (adv3 && v2_reg)
        begin
            for (int c = 0; c < 3; c++)
                loc_reg[c] <= 51'(prod_reg[0][c]) + 51'(prod_reg[1][c]) + 51'(prod_reg[2][c]);
            rad3_reg <= rad2_reg;
            sd3_reg  <= sd2_reg;
        end
    end

    // stage 4: numerators, cull test, depth
    always_comb
    begin
        zr         = loc_reg[2];
        nx_next    = zr * HALF_W + loc_reg[0] * PROJ_SCALE;
        ny_next    = zr * HALF_H - loc_reg[1] * PROJ_SCALE;
        nr_next    = {39'(rad3_reg * (sd3_reg.star ? FAC_STAR : FAC_PLANET)), 14'b0};
        z10        = 55'(zr) * 55'sd10;
        vis_next   = z10 > 55'sd1073741824;
        zt         = 37'((zr + (zr[50] ? 51'sd16383 : 51'sd0)) >>> 14);
        if (zt > 37'sd2147483647)
            depth_next = 32'h7fff_ffff;
        else if (zt < -37'sd2147483648)
            depth_next = 32'h8000_0000;
        else
            depth_next = zt[31:0];
        sd4_next       = sd3_reg;
        sd4_next.vis   = vis_next;
        sd4_next.depth = depth_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv4 && v3_reg)
        begin
            nx_reg  <= nx_next;
            ny_reg  <= ny_next;
            nr_reg  <= nr_next;
            z_reg   <= loc_reg[2];
            sd4_reg <= sd4_next;
        end
    end

    // stage 5: magnitudes and overflow check
    always_comb
    begin
        mag[LANE_X] = nx_reg[63] ? 64'(-nx_reg) : 64'(nx_reg);
        mag[LANE_Y] = ny_reg[63] ? 64'(-ny_reg) : 64'(ny_reg);
        mag[LANE_R] = 64'(nr_reg);
        d5_next.den  = z_reg;
        d5_next.quo  = '0;
        d5_next.neg  = {1'b0, ny_reg[63], nx_reg[63]};
        d5_next.side = sd4_reg;
        for (int l = 0; l < LANES; l++)
        begin
            d5_next.rem[l] = mag[l];
            d5_next.ovf[l] = {{(CMP_W-REM_W){1'b0}}, mag[l]} >= {z_reg, {QUO_W{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv5 && v4_reg)
            d5_reg <= d5_next;
    end

    pcp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_ready  (div_in_ready),
        .in_data   (d5_reg),
        .out_valid (div_out_valid),
        .out_ready (advo),
        .out_data  (div_out)
    );

    // output stage: sign, saturation, minimum radius, zeroing of culled bodies
    always_comb
    begin
        if (div_out.ovf[LANE_X] || div_out.quo[LANE_X][15])
            sx_next = div_out.neg[LANE_X] ? 16'h8000 : 16'h7fff;
        else
            sx_next = div_out.neg[LANE_X] ? 16'(-div_out.quo[LANE_X]) : div_out.quo[LANE_X];
        if (div_out.ovf[LANE_Y] || div_out.quo[LANE_Y][15])
            sy_next = div_out.neg[LANE_Y] ? 16'h8000 : 16'h7fff;
        else
            sy_next = div_out.neg[LANE_Y] ? 16'(-div_out.quo[LANE_Y]) : div_out.quo[LANE_Y];
        if (div_out.ovf[LANE_R] || div_out.quo[LANE_R][15])
            r_next = 15'h7fff;
        else if (div_out.quo[LANE_R] < 16'd2)
            r_next = 15'd2;
        else
            r_next = div_out.quo[LANE_R][14:0];
        if (!div_out.side.vis)
        begin
            sx_next = '0;
            sy_next = '0;
            r_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advo && div_out_valid)
        begin
            m_axis_tdata <= {1'b0, div_out.side.color, div_out.side.depth, r_next, sy_next, sx_next};
            m_axis_tuser <= {div_out.side.star, div_out.side.vis};
        end
    end

    assign m_axis_tvalid = vo_reg;

    a_vis_radius: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[46:32] >= 15'd2)
        else $error("visible body with radius below minimum");

    a_culled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[46:0] == 47'd0)
        else $error("culled body with nonzero screen fields");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled while output empty");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> v1_reg && v5_reg && div_out_valid)
        else $error("input stalled with a bubble in the pipeline");

endmodule

`default_nettype wire

// ===== rtl/pcp_div.sv =====
// pipelined three-lane restoring divider, one quotient bit per stage
// depends on pcp_pkg
`default_nettype none

module pcp_div (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire pcp_pkg::div_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output pcp_pkg::div_t      out_data
);
    import pcp_pkg::*;

    div_t             st_reg [QUO_W];
    logic [QUO_W-1:0] v_reg;
    logic [QUO_W:0]   adv;

    assign adv[QUO_W] = out_ready;

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int B = QUO_W - 1 - k;
        div_t             src;
        div_t             nxt;
        logic             src_v;
        logic [CMP_W-1:0] trial;

        if (k == 0) begin : g_first
            assign src   = in_data;
            assign src_v = in_valid;
        end else begin : g_rest
            assign src   = st_reg[k-1];
            assign src_v = v_reg[k-1];
        end

        assign adv[k] = !v_reg[k] || adv[k+1];
        assign trial  = {{QUO_W{1'b0}}, src.den} << B;

        always_comb
        begin
            nxt = src;
            for (int l = 0; l < LANES; l++)
            begin
                if ({{(CMP_W-REM_W){1'b0}}, src.rem[l]} >= trial)
                begin
                    nxt.rem[l]    = src.rem[l] - trial[REM_W-1:0];
                    nxt.quo[l][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv[k])
                v_reg[k] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (adv[k] && src_v)
                st_reg[k] <= nxt;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[QUO_W-1];
    assign out_data  = st_reg[QUO_W-1];

endmodule

`default_nettype wire
